// ===== src/pgg_pkg.sv =====
// Package for the go-to-goal PID controller.
// Holds shared constants, the arctangent table and controller/datapath structs.
// No dependencies.
package pgg_pkg;

    // Number of CORDIC rotation steps (8..32)
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_HD  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 4'd7;

    // Phases
    localparam logic [1:0] PH_AIM   = 2'd0;
    localparam logic [1:0] PH_DRIVE = 2'd1;
    localparam logic [1:0] PH_TURN  = 2'd2;
    localparam logic [1:0] PH_END   = 2'd3;

    // Multiplier operand select
    localparam logic [1:0] MSEL_P = 2'd0;
    localparam logic [1:0] MSEL_I = 2'd1;
    localparam logic [1:0] MSEL_D = 2'd2;

    // Command kinds
    localparam logic KIND_ANG = 1'b0;
    localparam logic KIND_LIN = 1'b1;

    // pi in Q30
    localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;

    typedef struct packed {
        logic [14:0]        ang_tol;
        logic [30:0]        dist_tol;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [15:0] final_heading;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       cor_start;
        logic       cor_sel;     // 0 quaternion, 1 goal delta
        logic       cap_head;
        logic       cap_bear;
        logic       sq_start;
        logic       err;
        logic       mul;
        logic [1:0] mul_sel;
        logic       acc;
        logic       fin;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic cor_busy;
        logic sq_busy;
        logic done;
    } sts_t;

    // atan(2^-i) in Q30
    function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [30:0] v;
        case (i)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            5'd24:   v = 31'd64;
            5'd25:   v = 31'd32;
            5'd26:   v = 31'd16;
            5'd27:   v = 31'd8;
            5'd28:   v = 31'd4;
            5'd29:   v = 31'd2;
            5'd30:   v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/pgg_if.sv =====
// Channel interfaces for the go-to-goal controller: odometry in, command out,
// configuration writes. Depends on nothing.
interface pgg_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, pos_x, pos_y, quat_z, quat_w, input ready);
    modport sink   (input valid, pos_x, pos_y, quat_z, quat_w, output ready);
endinterface

interface pgg_out_if;
    logic               valid;
    logic               ready;
    logic               command_kind;
    logic signed [31:0] command_value;
    logic [1:0]         phase_now;
    logic               phase_done;
    modport source (output valid, command_kind, command_value, phase_now, phase_done,
                    input ready);
    modport sink   (input valid, command_kind, command_value, phase_now, phase_done,
                    output ready);
endinterface

interface pgg_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pgg_dp.sv =====
// Datapath: CORDIC atan2, integer square root, PID multiply-accumulate, result regs.
// Depends on pgg_pkg.
module pgg_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pgg_pkg::cfg_t         cfg,
    input  pgg_pkg::cmd_t         cmd,
    output pgg_pkg::sts_t         sts,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [15:0]    quat_z,
    input  logic signed [15:0]    quat_w,
    output logic                  command_kind,
    output logic signed [31:0]    command_value,
    output logic [1:0]            phase_now,
    output logic                  phase_done
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ROT  = 2'd2;

    localparam logic [1:0] Q_IDLE = 2'd0;
    localparam logic [1:0] Q_MX   = 2'd1;
    localparam logic [1:0] Q_MY   = 2'd2;
    localparam logic [1:0] Q_RUN  = 2'd3;

    localparam logic signed [45:0] LVL_COARSE = 46'sh1_0000_0000;
    localparam logic signed [45:0] LVL_NORM   = 46'sh100_0000_0000;
    localparam logic [32:0]        MAG_LIM    = 33'h07FFF_FFFF;

    // Input sample
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] qz_reg, qw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            qz_reg <= quat_z;
            qw_reg <= quat_w;
        end
    end

    // Goal delta
    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    assign dx  = 33'(cfg.goal_x) - 33'(px_reg);
    assign dy  = 33'(cfg.goal_y) - 33'(py_reg);
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);

    // ---------------- CORDIC vectoring ----------------
    localparam int STEP_W_L = pgg_pkg::STEP_W;
    logic [1:0]          cst_reg;
    logic signed [45:0]  cx_reg, cy_reg, cm_reg;
    logic signed [35:0]  cz_reg;
    logic [STEP_W_L-1:0] cstep_reg;

    logic signed [45:0] x0, y0, xn, yn, ayn, xs, ys;
    logic signed [35:0] zn, at;

    always_comb
    begin
        x0 = cmd.cor_sel ? 46'(dx) : 46'(qw_reg);
        y0 = cmd.cor_sel ? 46'(dy) : 46'(qz_reg);
        if (x0 < 0)
        begin
            xn = -x0;
            yn = -y0;
            zn = (y0 >= 0) ? pgg_pkg::PI_Q30 : -pgg_pkg::PI_Q30;
        end
        else
        begin
            xn = x0;
            yn = y0;
            zn = '0;
        end
        ayn = (yn < 0) ? -yn : yn;
        xs  = cx_reg >>> cstep_reg;
        ys  = cy_reg >>> cstep_reg;
        at  = $signed({5'b0, pgg_pkg::atan_q30(cstep_reg)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg <= C_IDLE;
        end
        else
        begin
            case (cst_reg)
                C_IDLE:
                begin
                    if (cmd.cor_start)
                    begin
                        if (x0 == 0 && y0 == 0)
                        begin
                            cz_reg <= '0;
                        end
                        else
                        begin
                            cx_reg  <= xn;
                            cy_reg  <= yn;
                            cz_reg  <= zn;
                            cm_reg  <= (ayn > xn) ? ayn : xn;
                            cst_reg <= C_NORM;
                        end
                    end
                end
                C_NORM:
                begin
                    // scale up to the working range, eight bits at a time when far
                    if (cm_reg < LVL_COARSE)
                    begin
                        cx_reg <= cx_reg <<< 8;
                        cy_reg <= cy_reg <<< 8;
                        cm_reg <= cm_reg <<< 8;
                    end
                    else if (cm_reg < LVL_NORM)
                    begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                        cm_reg <= cm_reg <<< 1;
                    end
                    else
                    begin
                        cstep_reg <= '0;
                        cst_reg   <= C_ROT;
                    end
                end
                C_ROT:
                begin
                    if (cy_reg >= 0)
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + at;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - at;
                    end
                    if (cstep_reg == STEP_W_L'(pgg_pkg::CORDIC_STEPS - 1))
                        cst_reg <= C_IDLE;
                    cstep_reg <= cstep_reg + 1'b1;
                end
                default:
                begin
                    cst_reg <= C_IDLE;
                end
            endcase
        end
    end

    // Q30 to Q4.12 with round half up
    logic signed [36:0] head_wide, bear_wide;
    logic signed [17:0] heading_reg, bearing_reg;
    assign head_wide = {cz_reg, 1'b0} + 37'sd131072;
    assign bear_wide = 37'(cz_reg) + 37'sd131072;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_head)
            heading_reg <= head_wide[35:18];
        if (cmd.cap_bear)
            bearing_reg <= bear_wide[35:18];
    end

    // ---------------- Integer square root ----------------
    logic [1:0]  qst_reg;
    logic [63:0] v_reg, r_reg, bit_reg;
    logic [30:0] dist_reg;
    logic [30:0] sq_op;
    logic [61:0] sq;
    logic [63:0] trial, r_nx, v_nx;

    always_comb
    begin
        sq_op = (qst_reg == Q_MX) ? adx[30:0] : ady[30:0];
        sq    = 62'(sq_op) * 62'(sq_op);
        trial = r_reg + bit_reg;
        if (v_reg >= trial)
        begin
            v_nx = v_reg - trial;
            r_nx = (r_reg >> 1) + bit_reg;
        end
        else
        begin
            v_nx = v_reg;
            r_nx = r_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qst_reg <= Q_IDLE;
        end
        else
        begin
            case (qst_reg)
                Q_IDLE:
                begin
                    if (cmd.sq_start)
                    begin
                        if (adx >= MAG_LIM || ady >= MAG_LIM)
                            dist_reg <= MAG_LIM[30:0];
                        else
                            qst_reg <= Q_MX;
                    end
                end
                Q_MX:
                begin
                    v_reg   <= 64'(sq);
                    qst_reg <= Q_MY;
                end
                Q_MY:
                begin
                    v_reg   <= v_reg + 64'(sq);
                    r_reg   <= '0;
                    bit_reg <= 64'h4000_0000_0000_0000;
                    qst_reg <= Q_RUN;
                end
                Q_RUN:
                begin
                    v_reg   <= v_nx;
                    r_reg   <= r_nx;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        dist_reg <= (r_nx > 64'(MAG_LIM)) ? MAG_LIM[30:0] : r_nx[30:0];
                        qst_reg  <= Q_IDLE;
                    end
                end
                default:
                begin
                    qst_reg <= Q_IDLE;
                end
            endcase
        end
    end

    // ---------------- PID ----------------
    logic signed [31:0] e_reg, prev_reg;
    logic signed [39:0] sum_reg;
    logic               done_reg;
    logic signed [56:0] prod_reg;
    logic signed [58:0] acc_reg;

    logic signed [17:0] target;
    logic signed [18:0] ang_e, ang_abs;
    logic signed [31:0] e_nx;
    logic               done_nx;
    logic signed [40:0] sum_wide;
    logic signed [39:0] sum_nx;
    logic signed [32:0] diff;
    logic signed [15:0] mul_a;
    logic signed [40:0] mul_b;
    logic signed [58:0] acc_sh;
    logic signed [31:0] eff;

    always_comb
    begin
        target  = (cmd.phase == pgg_pkg::PH_AIM) ? bearing_reg : 18'(cfg.final_heading);
        ang_e   = 19'(target) - 19'(heading_reg);
        ang_abs = ang_e[18] ? -ang_e : ang_e;
        if (cmd.phase == pgg_pkg::PH_DRIVE)
        begin
            e_nx    = $signed({1'b0, dist_reg});
            done_nx = dist_reg <= cfg.dist_tol;
        end
        else
        begin
            e_nx    = 32'(ang_e);
            done_nx = ang_abs[17:0] <= {3'b0, cfg.ang_tol};
        end
        sum_wide = 41'(sum_reg) + 41'(e_nx);
        if (sum_wide[40] != sum_wide[39])
            sum_nx = sum_wide[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
        else
            sum_nx = sum_wide[39:0];

        diff = 33'(e_reg) - 33'(prev_reg);
        case (cmd.mul_sel)
            pgg_pkg::MSEL_P:
            begin
                mul_a = cfg.gain_p;
                mul_b = 41'(e_reg);
            end
            pgg_pkg::MSEL_I:
            begin
                mul_a = cfg.gain_i;
                mul_b = 41'(sum_reg);
            end
            default:
            begin
                mul_a = cfg.gain_d;
                mul_b = 41'(diff);
            end
        endcase

        acc_sh = (cmd.phase == pgg_pkg::PH_DRIVE) ? (acc_reg >>> 8) : (acc_reg >>> 4);
        if (acc_sh[58:31] != {28{acc_sh[31]}})
            eff = acc_sh[58] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            eff = acc_sh[31:0];
    end

    // PID history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else if (cmd.err)
        begin
            sum_reg <= sum_nx;
        end
        else if (cmd.fin)
        begin
            if (done_reg && cmd.phase != pgg_pkg::PH_TURN)
            begin
                sum_reg  <= '0;
                prev_reg <= '0;
            end
            else
            begin
                prev_reg <= e_reg;
            end
        end
    end

    // Error, multiply and accumulate, result
    always_ff @(posedge clk)
    begin
        if (cmd.err)
        begin
            e_reg    <= e_nx;
            done_reg <= done_nx;
            acc_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            acc_reg <= acc_reg + 59'(prod_reg);
        end
        if (cmd.mul)
            prod_reg <= mul_a * mul_b;
        if (cmd.fin)
        begin
            command_kind  <= (cmd.phase == pgg_pkg::PH_DRIVE) ? pgg_pkg::KIND_LIN
                                                               : pgg_pkg::KIND_ANG;
            command_value <= done_reg ? 32'sd0 : eff;
            phase_now     <= cmd.phase;
            phase_done    <= done_reg;
        end
    end

    assign sts.cor_busy = (cst_reg != C_IDLE);
    assign sts.sq_busy  = (qst_reg != Q_IDLE);
    assign sts.done     = done_reg;

endmodule

// ===== src/pgg_ctrl.sv =====
// Controller: sequences one odometry transaction through the datapath and
// tracks the phase. Depends on pgg_pkg.
module pgg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  pgg_pkg::sts_t  sts,
    output pgg_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HEAD  = 4'd1;
    localparam logic [3:0] S_HWAIT = 4'd2;
    localparam logic [3:0] S_BEAR  = 4'd3;
    localparam logic [3:0] S_BWAIT = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_SWAIT = 4'd6;
    localparam logic [3:0] S_ERR   = 4'd7;
    localparam logic [3:0] S_M0    = 4'd8;
    localparam logic [3:0] S_M1    = 4'd9;
    localparam logic [3:0] S_M2    = 4'd10;
    localparam logic [3:0] S_M3    = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.phase  = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (phase_reg == pgg_pkg::PH_DRIVE)
                        state_next = S_SQ;
                    else if (phase_reg != pgg_pkg::PH_END)
                        state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.cor_start = 1'b1;
                state_next    = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (!sts.cor_busy)
                begin
                    cmd.cap_head = 1'b1;
                    state_next   = (phase_reg == pgg_pkg::PH_AIM) ? S_BEAR : S_ERR;
                end
            end
            S_BEAR:
            begin
                cmd.cor_start = 1'b1;
                cmd.cor_sel   = 1'b1;
                state_next    = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (!sts.cor_busy)
                begin
                    cmd.cap_bear = 1'b1;
                    state_next   = S_ERR;
                end
            end
            S_SQ:
            begin
                cmd.sq_start = 1'b1;
                state_next   = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (!sts.sq_busy)
                    state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.err    = 1'b1;
                state_next = S_M0;
            end
            S_M0:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = pgg_pkg::MSEL_P;
                state_next  = S_M1;
            end
            S_M1:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = pgg_pkg::MSEL_I;
                cmd.acc     = 1'b1;
                state_next  = S_M2;
            end
            S_M2:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = pgg_pkg::MSEL_D;
                cmd.acc     = 1'b1;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.acc    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
                if (sts.done)
                    phase_next = phase_reg + 1'b1;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= pgg_pkg::PH_AIM;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== src/pid_go_to_goal_controller.sv =====
// Go-to-goal PID controller: aim, drive, final turn.
// Aim runs a heading and a bearing CORDIC pass, final turn a heading pass, and drive an
// integer square root (skipped, distance saturated, when the goal delta is out of range).
// A zero vector needs no CORDIC pass; else a pass scales up, then runs 16 rotation steps.
// One transaction at a time: the next input can be taken in the cycle after the result is
// accepted; once finished, inputs are taken every cycle with no result. Reset clears
// phase, PID history and all configuration registers to zero.
module pid_go_to_goal_controller (
    input  logic      clk,
    input  logic      rst_n,
    pgg_in_if.sink    in_ch,
    pgg_out_if.source out_ch,
    pgg_cfg_if.sink   cfg_ch
);

    pgg_pkg::cfg_t cfg_reg;
    pgg_pkg::cmd_t cmd;
    pgg_pkg::sts_t sts;

    // Configuration registers; unknown indexes are dropped
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                pgg_pkg::REG_ANGLE_TOL: cfg_reg.ang_tol       <= cfg_ch.data[14:0];
                pgg_pkg::REG_DIST_TOL:  cfg_reg.dist_tol      <= cfg_ch.data[30:0];
                pgg_pkg::REG_GOAL_X:    cfg_reg.goal_x        <= cfg_ch.data;
                pgg_pkg::REG_GOAL_Y:    cfg_reg.goal_y        <= cfg_ch.data;
                pgg_pkg::REG_FINAL_HD:  cfg_reg.final_heading <= cfg_ch.data[15:0];
                pgg_pkg::REG_GAIN_P:    cfg_reg.gain_p        <= cfg_ch.data[15:0];
                pgg_pkg::REG_GAIN_I:    cfg_reg.gain_i        <= cfg_ch.data[15:0];
                pgg_pkg::REG_GAIN_D:    cfg_reg.gain_d        <= cfg_ch.data[15:0];
                default:                cfg_reg               <= cfg_reg;
            endcase
        end
    end

    pgg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pgg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .sts           (sts),
        .pos_x         (in_ch.pos_x),
        .pos_y         (in_ch.pos_y),
        .quat_z        (in_ch.quat_z),
        .quat_w        (in_ch.quat_w),
        .command_kind  (out_ch.command_kind),
        .command_value (out_ch.command_value),
        .phase_now     (out_ch.phase_now),
        .phase_done    (out_ch.phase_done)
    );

endmodule
